// ===== rtl/core/dfs_topological_sort_macros.svh =====
// Assertion macros for the topological sorter.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef DFS_TOPOLOGICAL_SORT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_MACROS_SVH
`ifndef SYNTHESIS
`define DFS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFS_ASSERT(label, expr, msg)
`define DFS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dfs_pkg.sv =====
// Shared types and constants of the topological sorter.
// No dependencies.
`default_nettype none
package dfs_pkg;
  localparam int NODES_DEF = 32;
  localparam int NODE_W    = 5;
  localparam int ROW_W     = 32;
  localparam int CFG_W     = 6;
  localparam logic [CFG_W-1:0] NC_RESET = 6'd32;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_RUN   = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [4:0]        row_index;
    logic [ROW_W-1:0]  row_bits;
  } dfs_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              cyclic;
    logic              last;
  } dfs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SCAN,
    ST_POP,
    ST_CYC,
    ST_RD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic wr_row;
    logic start;
    logic pass2;
    logic root_inc;
    logic root_open;
    logic finish_node;
    logic pop_rd;
    logic pop_load;
    logic push;
    logic j_inc;
    logic emit_start;
    logic emit_rd;
    logic emit_next;
    logic show_cyc;
  } dfs_ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic detect;
    logic root_done;
    logic root_white;
    logic j_done;
    logic edge_set;
    logic j_grey;
    logic j_white;
    logic can_push;
    logic sp_zero;
    logic k_last;
  } dfs_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/dfs_dpath.sv =====
// Datapath: adjacency, stack and order memories, colour flags, counters.
// Depends on dfs_pkg.
`default_nettype none
module dfs_dpath #(
  parameter int NODES = dfs_pkg::NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dfs_pkg::CFG_W-1:0] cfg_wdata_i,
  input  dfs_pkg::dfs_in_t          in_i,
  input  dfs_pkg::dfs_ctl_t         ctl_i,
  output dfs_pkg::dfs_sts_t         sts_o,
  output dfs_pkg::dfs_out_t         out_o
);
  import dfs_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  logic [ROW_W-1:0] adj_mem [NODES];
  logic [NW-1:0]    stk_v_mem [NODES];
  logic [CW-1:0]    stk_n_mem [NODES];
  logic [NW-1:0]    ord_mem [NODES];

  logic [ROW_W-1:0] adj_rd_q;
  logic [NW-1:0]    stk_v_rd_q;
  logic [CW-1:0]    stk_n_rd_q;
  logic [NW-1:0]    ord_rd_q;

  logic [CFG_W-1:0] nc_q;
  logic             detect_q;
  logic [CW-1:0]    root_q, j_q, ptr_q, k_q;
  logic [NW-1:0]    v_q, sp_q;
  logic [NODES-1:0] grey_q, black_q;

  logic [CW-1:0] cnt;
  logic [NW-1:0] jn, rn;
  logic [6:0]    jx;
  logic          adj_re;
  logic [NW-1:0] adj_ra;

  assign cnt = (7'(nc_q) > 7'(NODES)) ? CW'(NODES) : CW'(nc_q);
  assign jn  = NW'(j_q);
  assign rn  = NW'(root_q);
  assign jx  = 7'(j_q);

  assign sts_o.cnt_zero   = (cnt == '0);
  assign sts_o.detect     = detect_q;
  assign sts_o.root_done  = (root_q == cnt);
  assign sts_o.root_white = !grey_q[rn] && !black_q[rn];
  assign sts_o.j_done     = (j_q == cnt);
  // rows carry 32 bits; neighbors beyond that have no edge
  assign sts_o.edge_set   = (jx < 7'(ROW_W)) && adj_rd_q[jx[4:0]];
  assign sts_o.j_grey     = grey_q[jn];
  assign sts_o.j_white    = !grey_q[jn] && !black_q[jn];
  assign sts_o.can_push   = (sp_q < NW'(NODES - 1));
  assign sts_o.sp_zero    = (sp_q == '0);
  assign sts_o.k_last     = (k_q == cnt - CW'(1));

  assign out_o.node   = ctl_i.show_cyc ? '0 : NODE_W'(ord_rd_q);
  assign out_o.cyclic = ctl_i.show_cyc;
  assign out_o.last   = ctl_i.show_cyc | sts_o.k_last;

  always_comb begin
    adj_re = 1'b1;
    adj_ra = rn;
    priority if (ctl_i.root_open) begin
      adj_ra = rn;
    end else if (ctl_i.push) begin
      adj_ra = jn;
    end else if (ctl_i.pop_load) begin
      adj_ra = stk_v_rd_q;
    end else begin
      adj_re = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_row && (7'(in_i.row_index) < 7'(NODES))) begin
      adj_mem[NW'(in_i.row_index)] <= in_i.row_bits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      stk_v_mem[sp_q] <= v_q;
      stk_n_mem[sp_q] <= j_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop_rd) begin
      stk_v_rd_q <= stk_v_mem[sp_q - NW'(1)];
      stk_n_rd_q <= stk_n_mem[sp_q - NW'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish_node && !detect_q) begin
      ord_mem[NW'(ptr_q - CW'(1))] <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_rd) begin
      ord_rd_q <= ord_mem[NW'(k_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q     <= NC_RESET;
      detect_q <= 1'b0;
      root_q   <= '0;
      j_q      <= '0;
      ptr_q    <= '0;
      k_q      <= '0;
      v_q      <= '0;
      sp_q     <= '0;
      grey_q   <= '0;
      black_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        nc_q <= cfg_wdata_i;
      end
      if (ctl_i.start || ctl_i.pass2) begin
        grey_q   <= '0;
        black_q  <= '0;
        root_q   <= '0;
        detect_q <= ctl_i.start;
        ptr_q    <= cnt;
      end
      if (ctl_i.root_inc) begin
        root_q <= root_q + CW'(1);
      end
      if (ctl_i.root_open) begin
        grey_q[rn] <= 1'b1;
        v_q        <= rn;
        j_q        <= '0;
        sp_q       <= '0;
      end
      if (ctl_i.push) begin
        grey_q[jn] <= 1'b1;
        v_q        <= jn;
        j_q        <= '0;
        sp_q       <= sp_q + NW'(1);
      end
      if (ctl_i.j_inc) begin
        j_q <= j_q + CW'(1);
      end
      if (ctl_i.finish_node) begin
        grey_q[v_q]  <= 1'b0;
        black_q[v_q] <= 1'b1;
        if (!detect_q) begin
          ptr_q <= ptr_q - CW'(1);
        end
      end
      if (ctl_i.pop_rd) begin
        sp_q <= sp_q - NW'(1);
      end
      if (ctl_i.pop_load) begin
        v_q <= stk_v_rd_q;
        j_q <= stk_n_rd_q;
      end
      if (ctl_i.emit_start) begin
        k_q <= '0;
      end
      if (ctl_i.emit_next) begin
        k_q <= k_q + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dfs_ctrl.sv =====
// Controller state machine: sequences row loads, both search passes and
// result delivery. Depends on dfs_pkg.
`default_nettype none
module dfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  dfs_pkg::dfs_sts_t sts_i,
  output dfs_pkg::dfs_ctl_t ctl_o
);
  import dfs_pkg::*;

  state_e state_q, state_d;
  logic   in_fire, out_take, cycle_hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_CYC) || (state_q == ST_OUT);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_o && !out_stall_i;
  assign cycle_hit   = sts_i.edge_set && sts_i.detect && sts_i.j_grey;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && func_i == FUNC_RUN && !sts_i.cnt_zero) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts_i.root_done) begin
          if (!sts_i.detect) state_d = ST_RD;
        end else if (sts_i.root_white) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.j_done) begin
          state_d = sts_i.sp_zero ? ST_ROOT : ST_POP;
        end else if (cycle_hit) begin
          state_d = ST_CYC;
        end
      end
      ST_POP:  state_d = ST_SCAN;
      ST_CYC:  if (out_take) state_d = ST_IDLE;
      ST_RD:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_take) state_d = sts_i.k_last ? ST_IDLE : ST_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ctl_o.wr_row = (func_i == FUNC_WRITE);
          ctl_o.start  = (func_i == FUNC_RUN) && !sts_i.cnt_zero;
        end
      end
      ST_ROOT: begin
        if (sts_i.root_done) begin
          ctl_o.pass2      = sts_i.detect;
          ctl_o.emit_start = !sts_i.detect;
        end else if (sts_i.root_white) begin
          ctl_o.root_open = 1'b1;
        end else begin
          ctl_o.root_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts_i.j_done) begin
          ctl_o.finish_node = 1'b1;
          ctl_o.root_inc    = sts_i.sp_zero;
          ctl_o.pop_rd      = !sts_i.sp_zero;
        end else if (cycle_hit) begin
          ctl_o = '0;
        end else if (sts_i.edge_set && sts_i.j_white && sts_i.can_push) begin
          ctl_o.push = 1'b1;
        end else begin
          ctl_o.j_inc = 1'b1;
        end
      end
      ST_POP:  ctl_o.pop_load = 1'b1;
      ST_CYC:  ctl_o.show_cyc = 1'b1;
      ST_RD:   ctl_o.emit_rd = 1'b1;
      ST_OUT:  ctl_o.emit_next = out_take && !sts_i.k_last;
      default: ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dfs_topological_sort.sv =====
// Top level of the depth-first topological sorter with cycle detection.
// Depends on dfs_pkg, dfs_ctrl, dfs_dpath and the assertion macro header.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_i  (func, row_index, row_bits)
//   out      output     out_valid_o/out_stall_i out_o (node, cyclic, last)
//   cfg      input      cfg_we_i               cfg_wdata_i (node_count)
//
// A row load is taken while idle and leaves the block idle; rows stream back to back.
// A run walks one neighbor per cycle, plus the ROOT state per root visit and the POP
// state per stack pop, in both passes. Each result is read from the order memory
// in ST_RD and then shown in ST_OUT.
// Input stalls from run start until the last result is taken.
// Reset clears control state; memories are not cleared.
`default_nettype none
`include "dfs_topological_sort_macros.svh"
module dfs_topological_sort #(
  parameter int NODES = dfs_pkg::NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dfs_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  dfs_pkg::dfs_in_t          in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output dfs_pkg::dfs_out_t         out_o
);
  import dfs_pkg::*;

  dfs_ctl_t ctl;
  dfs_sts_t sts;

  dfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (in_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dfs_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_o       (out_o)
  );

  // results only appear while a run holds off new requests
  `DFS_ASSERT(a_out_busy, !out_valid_o || in_stall_o, "result shown while idle")
  // a cycle report is always the final result
  `DFS_ASSERT(a_cyc_last, !(out_valid_o && out_o.cyclic) || out_o.last, "cyclic not last")
  // a row load leaves the block ready for the next request
  `DFS_ASSERT_NEXT(a_row_ready, in_valid_i && !in_stall_o && (in_i.func == FUNC_WRITE),
                   !in_stall_o, "row load made block busy")
endmodule
`default_nettype wire

// ===== test/dfs_sort_checker.sv =====
// Checker for the topological sorter: watches the config, request and result channels,
// predicts each run's order or cycle flag and compares every result.
// Depends on dfs_pkg.
module dfs_sort_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  dfs_pkg::dfs_in_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  dfs_pkg::dfs_out_t out_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfs_pkg::*;

  typedef enum logic [1:0] {WHITE, GREY, BLACK} shade_e;

  logic [5:0]  node_count;
  logic [31:0] rows [32];
  shade_e      shade [32];
  int          frame_node [32];
  int          frame_next [32];
  logic [4:0]  finish_buf [32];
  int          finish_ptr;
  dfs_out_t    order_expected [$];

  assign pending_o = order_expected.size();

  function automatic bit walk_from(int root, int cnt, bit detect, logic [31:0] mask);
    int depth;
    int v;
    int j;
    logic [31:0] row;
    bit pushed;
    shade[root] = GREY;
    frame_node[0] = root;
    frame_next[0] = 0;
    depth = 1;
    while (depth > 0) begin
      v = frame_node[depth-1];
      row = rows[v] & mask;
      pushed = 0;
      while (frame_next[depth-1] < cnt) begin
        j = frame_next[depth-1];
        frame_next[depth-1] = j + 1;
        if (!row[j]) continue;
        if (detect && shade[j] == GREY) return 1;
        if (shade[j] == WHITE && depth < 32) begin
          shade[j] = GREY;
          frame_node[depth] = j;
          frame_next[depth] = 0;
          depth++;
          pushed = 1;
          break;
        end
      end
      if (pushed) continue;
      shade[v] = BLACK;
      if (!detect && finish_ptr > 0) begin
        finish_ptr--;
        finish_buf[finish_ptr] = v[4:0];
      end
      depth--;
    end
    return 0;
  endfunction

  task automatic predict_sort();
    int cnt;
    logic [31:0] mask;
    dfs_out_t res;
    cnt = (node_count > 32) ? 32 : node_count;
    if (cnt == 0) return;
    mask = (cnt == 32) ? 32'hFFFF_FFFF : ((32'd1 << cnt) - 1);
    foreach (shade[i]) shade[i] = WHITE;
    for (int i = 0; i < cnt; i++) begin
      if (shade[i] == WHITE && walk_from(i, cnt, 1, mask)) begin
        res.node = '0;
        res.cyclic = 1'b1;
        res.last = 1'b1;
        order_expected.push_back(res);
        return;
      end
    end
    foreach (shade[i]) shade[i] = WHITE;
    finish_ptr = cnt;
    for (int i = 0; i < cnt; i++)
      if (shade[i] == WHITE) void'(walk_from(i, cnt, 0, mask));
    for (int i = 0; i < cnt; i++) begin
      res.node = finish_buf[i];
      res.cyclic = 1'b0;
      res.last = (i == cnt - 1);
      order_expected.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dfs_out_t want;
    if (!rst_ni) begin
      node_count <= NC_RESET;
      fail_count_o <= 0;
      order_expected.delete();
    end else begin
      if (cfg_we_i) node_count <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_i.func == FUNC_WRITE) rows[in_i.row_index] = in_i.row_bits;
        else predict_sort();
      end
      if (out_valid_i && !out_stall_i) begin
        if (order_expected.size() == 0) begin
          $display("%0t: unexpected result expected none actual node=%0d cyclic=%0b last=%0b",
                   $time, out_i.node, out_i.cyclic, out_i.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = order_expected.pop_front();
          if (want.node !== out_i.node || want.cyclic !== out_i.cyclic ||
              want.last !== out_i.last) begin
            $display("%0t: mismatch expected n=%0d c=%0b l=%0b actual n=%0d c=%0b l=%0b",
                     $time, want.node, want.cyclic, want.last,
                     out_i.node, out_i.cyclic, out_i.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/dfs_topological_sort_tb.sv =====
// Testbench top for the topological sorter: loads random DAGs and cyclic graphs,
// runs sorts under several node counts with random gaps and stalls.
// Depends on dfs_pkg, dfs_topological_sort and dfs_sort_checker.
module dfs_topological_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfs_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_WAIT = 2600;
  localparam int ITEMS      = 220;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  dfs_in_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dfs_out_t out_res;
  int       fail_count;
  int       pending;
  int       sent = 0;
  int       idle_cycles = 0;
  int       out_hold = 0;
  bit       quiet = 1'b0;
  int       node_cnt = 32;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  dfs_topological_sort u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_res)
  );

  dfs_sort_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // result-side backpressure: new hold drawn after each taken result
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) out_hold = quiet ? 0 : $urandom_range(0, 8);
    else if (out_hold > 0) out_hold = out_hold - 1;
    out_stall <= (out_hold > 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_req(logic func, logic [4:0] idx, logic [31:0] bits);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req.func <= func;
    in_req.row_index <= idx;
    in_req.row_bits <= bits;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic set_node_count(logic [5:0] val);
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    node_cnt = (val > 32) ? 32 : val;
  endtask

  // flavor 0: DAG, 1: one back edge, 2: self-loop; high bits are noise
  task automatic load_graph(int flavor);
    int perm [32];
    logic [31:0] g [32];
    logic [31:0] mask;
    int tmp, k, a, b, dens;
    mask = (node_cnt >= 32) ? 32'hFFFF_FFFF : ((32'd1 << node_cnt) - 1);
    for (int i = 0; i < 32; i++) begin
      perm[i] = i;
      g[i] = '0;
    end
    for (int i = node_cnt - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[k]; perm[k] = tmp;
    end
    dens = $urandom_range(0, 100);
    for (a = 0; a < node_cnt; a++)
      for (b = a + 1; b < node_cnt; b++)
        if ($urandom_range(0, 99) < dens) g[perm[a]][perm[b]] = 1'b1;
    if (node_cnt > 1 && flavor == 1) begin
      a = $urandom_range(1, node_cnt - 1);
      b = $urandom_range(0, a - 1);
      g[perm[b]][perm[a]] = 1'b1;
      g[perm[a]][perm[b]] = 1'b1;
    end
    if (node_cnt > 0 && flavor == 2) begin
      a = $urandom_range(0, node_cnt - 1);
      g[a][a] = 1'b1;
    end
    for (int i = 0; i < node_cnt; i++)
      send_req(FUNC_WRITE, i[4:0], g[i] | ($urandom() & ~mask));
    // stray write to a row outside the graph
    if ($urandom_range(0, 3) == 0 && node_cnt < 32)
      send_req(FUNC_WRITE, 5'($urandom_range(node_cnt, 31)), $urandom());
  endtask

  initial begin
    logic [5:0] plan [10];
    int round;
    plan = '{6'd1, 6'd2, 6'd0, 6'd63, 6'd5, 6'd3, 6'd8, 6'd32, 6'd4, 6'd6};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every row loaded once so no run reads an unwritten row
    for (int i = 0; i < 32; i++) send_req(FUNC_WRITE, i[4:0], 32'h0);
    send_req(FUNC_RUN, 5'd0, 32'h0);
    send_req(FUNC_WRITE, 5'd0, 32'hFFFF_FFFF);
    send_req(FUNC_RUN, 5'd31, 32'hFFFF_FFFF);
    send_req(FUNC_WRITE, 5'd0, 32'h0);
    send_req(FUNC_WRITE, 5'd31, 32'h8000_0000);
    send_req(FUNC_RUN, 5'd0, 32'h0);
    send_req(FUNC_WRITE, 5'd31, 32'h0);
    send_req(FUNC_WRITE, 5'd0, 32'hFFFF_FFFE);
    send_req(FUNC_RUN, 5'd0, 32'h0);

    round = 0;
    while (sent < ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (round < 10) set_node_count(plan[round]);
      else if ($urandom_range(0, 7) == 0) set_node_count(6'($urandom_range(0, 63)));
      else set_node_count(6'($urandom_range(1, 10)));
      repeat ($urandom_range(2, 4)) begin
        if (sent < ITEMS) begin
          tmp_flavor: begin
            int fl;
            fl = $urandom_range(0, 9);
            load_graph(fl < 6 ? 0 : (fl < 8 ? 1 : 2));
          end
          send_req(FUNC_RUN, 5'($urandom()), $urandom());
        end
      end
      round++;
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dfs_pkg.sv
rtl/core/dfs_dpath.sv
rtl/core/dfs_ctrl.sv
rtl/core/dfs_topological_sort.sv
test/dfs_sort_checker.sv
test/dfs_topological_sort_tb.sv
